FILE: sv/mcfir_pkg.sv
package mcfir_pkg;

   localparam int TAP_SLOTS    = 64;
   localparam int MAX_CHANNELS = 32;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int CH_W     = 5;
   localparam int CCNT_W   = 6;
   localparam int TCNT_W   = 7;
   localparam int TIDX_W   = 6;

   localparam int DIGIT_W    = 8;
   localparam int NUM_DIGITS = COEF_W / DIGIT_W;
   localparam int DCNT_W     = 2;
   localparam int PART_W     = SAMPLE_W + DIGIT_W + 1;
   localparam int ACC_W      = 56;
   localparam int FRAC_SHIFT = 20;

   localparam int DELAY_DEPTH = MAX_CHANNELS * TAP_SLOTS;
   localparam int DADDR_W     = $clog2(DELAY_DEPTH);

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ADDR     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_DATA     = 4'd3;

   localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(1 << FRAC_SHIFT);

   typedef struct packed {
      logic                acc_clear;
      logic                load;
      logic                step;
      logic [DCNT_W-1:0]   digit;
   } mac_ctrl_type;

endpackage

FILE: sv/mcfir_mac.sv
module mcfir_mac (
   input  logic                                   clock,
   input  mcfir_pkg::mac_ctrl_type                ctrl,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]  sample,
   input  logic signed [mcfir_pkg::COEF_W-1:0]    coef,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0]  result
);
   import mcfir_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [COEF_W-1:0]   coef_sr_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   logic signed [DIGIT_W:0]    dig;
   logic signed [PART_W-1:0]   part;
   logic signed [ACC_W-1:0]    part_ext;
   logic signed [ACC_W-1:0]    part_sh;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [ACC_W-FRAC_SHIFT-1:0] q;

   always_comb begin
      if (ctrl.digit == DCNT_W'(NUM_DIGITS - 1)) begin
         dig = {coef_sr_ff[DIGIT_W-1], coef_sr_ff[DIGIT_W-1:0]};
      end else begin
         dig = {1'b0, coef_sr_ff[DIGIT_W-1:0]};
      end
      part     = sample_ff * dig;
      part_ext = {{(ACC_W-PART_W){part[PART_W-1]}}, part};
      case (ctrl.digit)
         2'd0:    part_sh = part_ext;
         2'd1:    part_sh = part_ext <<< DIGIT_W;
         default: part_sh = part_ext <<< (2 * DIGIT_W);
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sample_ff  <= sample;
         coef_sr_ff <= coef;
      end else if (ctrl.step) begin
         coef_sr_ff <= coef_sr_ff >>> DIGIT_W;
      end
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctrl.step) begin
         acc_ff <= acc_ff + part_sh;
      end
   end

   always_comb begin
      rnd = acc_ff + ACC_W'(1 << (FRAC_SHIFT - 1));
      q   = rnd[ACC_W-1:FRAC_SHIFT];
      if (q > (ACC_W-FRAC_SHIFT)'(2**(SAMPLE_W-1) - 1)) begin
         result = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (q < -((ACC_W-FRAC_SHIFT)'(2**(SAMPLE_W-1)))) begin
         result = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         result = q[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: sv/mcfir_delay.sv
module mcfir_delay (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic [mcfir_pkg::DADDR_W-1:0]         addr,
   input  logic                                  wr_en,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0] wr_data,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0] rd_data,
   output logic                                  busy
);
   import mcfir_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
   logic [DADDR_W:0]           clr_cnt_ff;
   logic [DADDR_W:0]           clr_cnt_in;
   logic                       busy_ff;
   logic                       busy_in;

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in    = busy_ff;
      if (clear) begin
         clr_cnt_in = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (DADDR_W+1)'(DELAY_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         busy_ff    <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff[DADDR_W-1:0]] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

   assign busy = busy_ff;

endmodule

FILE: sv/multichannel_fir_filter.sv
// Multichannel FIR filter for interleaved Q1.23 audio with Q4.20 coefficients. For each
// request, every tap in use costs a delay-memory and coefficient-memory read, a load and
// the 8-bit digit-serial multiply-accumulate over three digits; then the response is handed
// over. After reset and after every write of the channel or tap count, a clearing pass
// zeroes all 2048 delay-memory entries, during which no request is accepted while
// configuration writes still are.
module multichannel_fir_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [mcfir_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic [mcfir_pkg::CH_W-1:0]              rsp_channel,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mcfir_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mcfir_pkg::CSR_DAT_W-1:0]         csr_data
);
   import mcfir_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_ADDR  = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [CCNT_W-1:0]          chan_cnt_ff;
   logic [TCNT_W-1:0]          tap_cnt_ff;
   logic [TIDX_W-1:0]          coef_addr_ff;
   logic [CCNT_W-1:0]          nch;
   logic [TCNT_W-1:0]          ntap;

   logic [CH_W-1:0]            counter_ff;
   logic [TIDX_W-1:0]          pos_ff [MAX_CHANNELS];
   logic [CH_W-1:0]            chan_ff;
   logic [TIDX_W-1:0]          p_ff;
   logic [TIDX_W-1:0]          idx_ff;
   logic [TCNT_W-1:0]          k_ff;
   logic [DCNT_W-1:0]          digit_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;

   logic signed [COEF_W-1:0]   coef_mem [TAP_SLOTS];
   logic [TAP_SLOTS-1:0]       coef_vld_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic                       coef_rd_vld_ff;
   logic                       coef_rd_k0_ff;
   logic signed [COEF_W-1:0]   coef_eff;

   logic                       csr_wr;
   logic                       count_wr;
   logic                       coef_wr;
   logic                       clr_busy;
   logic [DADDR_W-1:0]         d_addr;
   logic signed [SAMPLE_W-1:0] d_rd;
   logic signed [SAMPLE_W-1:0] mac_result;
   mac_ctrl_type               mac_ctrl;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic [CH_W-1:0]            rsp_channel_ff;

   logic [CH_W-1:0]            c_sel;
   logic [TIDX_W-1:0]          p_sel;
   logic [TIDX_W:0]            p_next;
   logic [CCNT_W-1:0]          c_next;
   logic                       last_tap;
   logic                       out_free;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;
   assign count_wr  = csr_wr & ((csr_index == REG_CHANNEL_COUNT) ||
                                (csr_index == REG_TAP_COUNT));
   assign coef_wr   = csr_wr & (csr_index == REG_COEF_DATA) &
                      ({1'b0, coef_addr_ff} < (TIDX_W+1)'(TAP_SLOTS));

   always_comb begin
      if (chan_cnt_ff == '0) begin
         nch = CCNT_W'(1);
      end else if (chan_cnt_ff > CCNT_W'(MAX_CHANNELS)) begin
         nch = CCNT_W'(MAX_CHANNELS);
      end else begin
         nch = chan_cnt_ff;
      end
      if (tap_cnt_ff == '0) begin
         ntap = TCNT_W'(1);
      end else if (tap_cnt_ff > TCNT_W'(TAP_SLOTS)) begin
         ntap = TCNT_W'(TAP_SLOTS);
      end else begin
         ntap = tap_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff  <= CCNT_W'(2);
         tap_cnt_ff   <= TCNT_W'(1);
         coef_addr_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_CHANNEL_COUNT: chan_cnt_ff  <= csr_data[CCNT_W-1:0];
            REG_TAP_COUNT:     tap_cnt_ff   <= csr_data[TCNT_W-1:0];
            REG_COEF_ADDR:     coef_addr_ff <= csr_data[TIDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem[coef_addr_ff] <= csr_data[COEF_W-1:0];
      end
      coef_rd_ff     <= coef_mem[k_ff[TIDX_W-1:0]];
      coef_rd_vld_ff <= coef_vld_ff[k_ff[TIDX_W-1:0]];
      coef_rd_k0_ff  <= (k_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_wr) begin
         coef_vld_ff[coef_addr_ff] <= 1'b1;
      end
   end

   always_comb begin
      if (coef_rd_vld_ff) begin
         coef_eff = coef_rd_ff;
      end else if (coef_rd_k0_ff) begin
         coef_eff = COEF_UNITY;
      end else begin
         coef_eff = '0;
      end
   end

   always_comb begin
      c_sel = ({1'b0, counter_ff} >= nch) ? '0 : counter_ff;
      p_sel = ({1'b0, pos_ff[c_sel]} >= ntap) ? '0 : pos_ff[c_sel];
      p_next = {1'b0, p_ff} + 1'b1;
      c_next = {1'b0, chan_ff} + 1'b1;
      last_tap = (k_ff + 1'b1) == ntap;
      out_free = ~rsp_valid_ff | rsp_ready;
   end

   assign req_ready = (state_ff == S_IDLE) & ~clr_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid && req_ready) state_in = S_WRITE;
         S_WRITE: state_in = S_ADDR;
         S_ADDR:  state_in = S_LOAD;
         S_LOAD:  state_in = S_MUL;
         S_MUL: begin
            if (digit_ff == DCNT_W'(NUM_DIGITS - 1)) begin
               state_in = last_tap ? S_DONE : S_ADDR;
            end
         end
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || count_wr) begin
         counter_ff <= '0;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (state_ff == S_WRITE) begin
         pos_ff[chan_ff] <= (p_next == ntap) ? '0 : p_next[TIDX_W-1:0];
         counter_ff      <= (c_next >= nch) ? '0 : c_next[CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         chan_ff   <= c_sel;
         p_ff      <= p_sel;
         idx_ff    <= p_sel;
         sample_ff <= req_sample;
         k_ff      <= '0;
      end else if (state_ff == S_MUL && digit_ff == DCNT_W'(NUM_DIGITS - 1)) begin
         k_ff   <= k_ff + 1'b1;
         idx_ff <= (idx_ff == '0) ? TIDX_W'(ntap - 1'b1) : idx_ff - 1'b1;
      end
      if (state_ff == S_MUL) begin
         digit_ff <= digit_ff + 1'b1;
      end else begin
         digit_ff <= '0;
      end
   end

   assign d_addr = DADDR_W'(chan_ff) * DADDR_W'(TAP_SLOTS) +
                   DADDR_W'((state_ff == S_WRITE) ? p_ff : idx_ff);

   mcfir_delay u_delay (
      .clock   (clock),
      .reset   (reset),
      .clear   (count_wr),
      .addr    (d_addr),
      .wr_en   (state_ff == S_WRITE),
      .wr_data (sample_ff),
      .rd_data (d_rd),
      .busy    (clr_busy)
   );

   always_comb begin
      mac_ctrl.acc_clear = (state_ff == S_WRITE);
      mac_ctrl.load      = (state_ff == S_LOAD);
      mac_ctrl.step      = (state_ff == S_MUL);
      mac_ctrl.digit     = digit_ff;
   end

   mcfir_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .sample (d_rd),
      .coef   (coef_eff),
      .result (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_filtered_ff <= mac_result;
         rsp_channel_ff  <= chan_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_channel  = rsp_channel_ff;

endmodule

FILE: tb/mcfir_checker.sv
module mcfir_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [mcfir_pkg::SAMPLE_W-1:0]  rsp_filtered,
   input  logic [mcfir_pkg::CH_W-1:0]             rsp_channel,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [mcfir_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mcfir_pkg::CSR_DAT_W-1:0]        csr_data,
   output int                                     fail_count,
   output int                                     pending,
   output int                                     checked
);
   import mcfir_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic [CH_W-1:0]            channel;
   } fir_out_type;

   logic [CCNT_W-1:0]          chan_count_reg;
   logic [TCNT_W-1:0]          tap_count_reg;
   logic [TIDX_W-1:0]          coef_addr_reg;
   logic signed [COEF_W-1:0]   coef_table [TAP_SLOTS];
   logic signed [SAMPLE_W-1:0] history [MAX_CHANNELS][TAP_SLOTS];
   int                         head_pos [MAX_CHANNELS];
   int                         next_chan;
   fir_out_type                expected_outputs [$];

   function automatic void clear_history();
      foreach (history[c, k]) history[c][k] = '0;
      foreach (head_pos[c]) head_pos[c] = 0;
      next_chan = 0;
   endfunction

   function automatic fir_out_type filter_sample(logic signed [SAMPLE_W-1:0] s);
      fir_out_type r;
      int       nch, ntap, c, p;
      longint   acc, q;
      nch  = (chan_count_reg == 0) ? 1 : (chan_count_reg > MAX_CHANNELS) ? MAX_CHANNELS
             : int'(chan_count_reg);
      ntap = (tap_count_reg == 0) ? 1 : (tap_count_reg > TAP_SLOTS) ? TAP_SLOTS
             : int'(tap_count_reg);
      c = (next_chan >= nch) ? 0 : next_chan;
      p = (head_pos[c] >= ntap) ? 0 : head_pos[c];
      history[c][p] = s;
      acc = 0;
      for (int k = 0; k < ntap; k++)
         acc += longint'(coef_table[k]) * longint'(history[c][(p + ntap - k) % ntap]);
      q = (acc + (longint'(1) << 19)) >>> FRAC_SHIFT;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      head_pos[c] = (p + 1) % ntap;
      next_chan = (c + 1 >= nch) ? 0 : c + 1;
      r.filtered = q[SAMPLE_W-1:0];
      r.channel = c[CH_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      fir_out_type want;
      if (reset) begin
         chan_count_reg <= CCNT_W'(2);
         tap_count_reg <= TCNT_W'(1);
         coef_addr_reg <= '0;
         foreach (coef_table[k]) coef_table[k] = '0;
         coef_table[0] = COEF_UNITY;
         clear_history();
         expected_outputs.delete();
         fail_count <= 0;
         checked <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_CHANNEL_COUNT: begin
                  chan_count_reg <= csr_data[CCNT_W-1:0];
                  clear_history();
               end
               REG_TAP_COUNT: begin
                  tap_count_reg <= csr_data[TCNT_W-1:0];
                  clear_history();
               end
               REG_COEF_ADDR: coef_addr_reg <= csr_data[TIDX_W-1:0];
               REG_COEF_DATA: begin
                  if (coef_addr_reg < TAP_SLOTS) coef_table[coef_addr_reg] = csr_data;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_outputs.push_back(filter_sample(req_sample));
         if (rsp_valid && rsp_ready) begin
            checked <= checked + 1;
            if (expected_outputs.size() == 0) begin
               $display("%0t: response with nothing expected: filtered %0d channel %0d",
                        $time, rsp_filtered, rsp_channel);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_outputs.pop_front();
               if (want.filtered !== rsp_filtered || want.channel !== rsp_channel) begin
                  $display("%0t: expected filtered %0d channel %0d, got filtered %0d channel %0d",
                           $time, want.filtered, want.channel, rsp_filtered, rsp_channel);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_outputs.size();
      end
   end
endmodule

FILE: tb/tb_multichannel_fir_filter.sv
module tb_multichannel_fir_filter;
   import mcfir_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 4'd9;
   localparam int QUIET_LIMIT = 60000;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic [CH_W-1:0]            rsp_channel;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DAT_W-1:0]       csr_data = '0;
   int                         fail_count, pending, checked;
   int                         send_idle_pct = 0, recv_stall_pct = 0;
   int                         quiet_cycles = 0;
   int                         phases = 0;
   logic [SAMPLE_W-1:0]        corner_samples [8] = '{24'h7FFFFF, 24'h800000, 24'h000000,
                                                      24'hFFFFFF, 24'h000001, 24'h555555,
                                                      24'hAAAAAA, 24'h3FFFFF};

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   multichannel_fir_filter dut (.*);
   mcfir_checker checker_i (.*);

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin
      int ntap, nch, count;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Passthrough after reset, including the sample extremes.
      foreach (corner_samples[i])
         send_sample(corner_samples[i]);
      drain();

      // Extreme coefficients drive the output into saturation.
      write_reg(REG_COEF_ADDR, 0);
      write_reg(REG_COEF_DATA, 24'h7FFFFF);
      write_reg(REG_UNUSED, 24'hFFFFFF);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'h000003);
      drain();
      write_reg(REG_COEF_DATA, 24'h800000);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      drain();

      // Zero counts, then oversized ones that clamp to the largest legal ones.
      write_reg(REG_COEF_DATA, COEF_UNITY);
      write_reg(REG_TAP_COUNT, 0);
      write_reg(REG_CHANNEL_COUNT, 0);
      send_sample(24'h123456);
      send_sample(24'h800000);
      drain();
      write_reg(REG_TAP_COUNT, 127);
      write_reg(REG_CHANNEL_COUNT, 63);
      write_reg(REG_COEF_ADDR, 63);
      write_reg(REG_COEF_DATA, 24'h0FFFFF);
      repeat (4) send_sample(random_sample());
      drain();
      write_reg(REG_CHANNEL_COUNT, 2);
      write_reg(REG_CHANNEL_COUNT, 2);
      repeat (3) send_sample(random_sample());
      drain();

      count = 0;
      while (count < 1620) begin
         case (phases % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 50; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 50; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         ntap = ($urandom_range(7) == 0) ? $urandom_range(48, 64) : $urandom_range(1, 8);
         nch = ($urandom_range(5) == 0) ? (($urandom_range(1)) ? 32 : 1) : $urandom_range(1, 8);
         write_reg(REG_CHANNEL_COUNT, nch);
         write_reg(REG_TAP_COUNT, ntap);
         for (int k = 0; k < ntap; k++) begin
            write_reg(REG_COEF_ADDR, k);
            if ($urandom_range(3) == 0)
               write_reg(REG_COEF_DATA, $urandom);
            else
               write_reg(REG_COEF_DATA, $signed($urandom_range(0, 1 << 19)) - (1 << 18));
         end
         for (int i = 0; i < ((ntap > 8) ? 40 : 130); i++) begin
            send_sample(random_sample());
            count++;
            if (i == 60) drain();
         end
         drain();
         phases++;
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Checked %0d filtered samples over %0d random settings of channels, taps",
               checked, phases);
      $display("and coefficients, with idle and stall patterns on both channels.");
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
